### hw/rtl/tdah_pkg.sv
// Shared types and constants for the tilt dead-zone / average / hold block.
// No dependencies.
`timescale 1ns / 1ps

package tdah_pkg;

    localparam int AXIS_W     = 17;
    localparam int AXIS_LIMIT = 46080;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 56;

    localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 16'd256;
    localparam logic [CFG_W-1:0] HOLD_THR_RST  = 16'd1280;

    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE      = 1'b0,
        REG_HOLD_THRESHOLD = 1'b1
    } cfg_idx_t;

    function automatic axis_t sat_axis(input axis_t x);
        axis_t lim;
        lim = AXIS_W'(AXIS_LIMIT);
        if (x > lim)
        begin
            return lim;
        end
        if (x < -lim)
        begin
            return -lim;
        end
        return x;
    endfunction

endpackage

### hw/rtl/tilt_deadzone_average_hold_top.sv
// Top level of the tilt dead-zone / moving-average / hold block.
// Depends on tdah_pkg and tdah_ram.
`timescale 1ns / 1ps

// One tilt sample per request, one smoothed result per request, one request per
// cycle sustained while the output is not stalled. The window lives in a RAM
// with a registered read port whose read address is prefetched from the write
// pointer, and the averaging multiply and the hold compare on the registered
// per-axis running sums sit in combinational logic ahead of the output register.
// Input ready follows output ready through that register only. The window is
// cleared at reset by per-entry valid bits, so no clearing pass is needed and
// samples are taken right after reset. Averages truncate toward zero. The user must
// write dead_zone and hold_threshold only while the block is idle; the block does not enforce it.
module tilt_deadzone_average_hold_top
    import tdah_pkg::*;
#(
    parameter int WINDOW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // raw_axis_a, raw_axis_b, raw_axis_c, zero pad
    input  logic                 s_axis_tuser,   // sample_valid
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // out_roll, out_pitch, out_yaw, zero pad
    output logic                 m_axis_tuser    // held
);

    localparam int PW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = AXIS_W + $clog2(WINDOW);
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + $clog2(WINDOW);
    localparam int RCP_W   = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam int ENTRY_W = 3 * AXIS_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
    localparam longint SUM_LIM = longint'(WINDOW) * AXIS_LIMIT;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [AXIS_W:0]  wide_t;

    localparam logic [RCP_W-1:0] RCP     = RCP_W'(RECIP);
    localparam sum_t             SUM_MAX = SUM_W'(SUM_LIM);

    logic [CFG_W-1:0]   dz_reg;
    logic [CFG_W-1:0]   thr_reg;
    sum_t               sum_reg [3];
    sum_t               sum_next [3];
    axis_t              last_reg [3];
    axis_t              out_reg [3];
    logic               held_reg;
    logic               m_valid_reg;
    logic [PW-1:0]      pos_reg;
    logic [PW-1:0]      pos_inc;
    logic [WINDOW-1:0]  vld_reg;
    logic               byp_reg;
    logic [ENTRY_W-1:0] byp_data_reg;

    logic               accept;
    logic [PW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;

    logic               neg [3];
    logic [MAG_W-1:0]   mag [3];
    logic [PROD_W-1:0]  prod [3];
    axis_t              quot [3];
    axis_t              avg [3];
    wide_t              diff [3];
    wide_t              adiff [3];
    logic [2:0]         far;
    logic               hold;
    axis_t              res [3];
    axis_t              raw [3];
    axis_t              sat [3];
    logic [2:0]         dead;
    wide_t              dz_w;
    axis_t              smp [3];
    axis_t              old [3];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign pos_inc       = (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
    assign rd_addr       = accept ? pos_inc : pos_reg;
    assign dz_w          = wide_t'({2'b00, dz_reg});
    assign wr_data       = {smp[2], smp[1], smp[0]};

    tdah_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_reg),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg[k]   = sum_reg[k][SUM_W-1];
            mag[k]   = MAG_W'(neg[k] ? -sum_reg[k] : sum_reg[k]);
            prod[k]  = PROD_W'(mag[k]) * PROD_W'(RCP);
            quot[k]  = AXIS_W'(prod[k] >> SHIFT);
            avg[k]   = neg[k] ? -quot[k] : quot[k];
            diff[k]  = wide_t'(avg[k]) - wide_t'(last_reg[k]);
            adiff[k] = diff[k][AXIS_W] ? -diff[k] : diff[k];
            far[k]   = adiff[k] >= wide_t'({2'b00, thr_reg});
        end
        hold = ~|far;
        for (int k = 0; k < 3; k++)
        begin
            res[k]  = hold ? last_reg[k] : avg[k];
            raw[k]  = s_axis_tdata[k*AXIS_W +: AXIS_W];
            sat[k]  = sat_axis(raw[k]);
            dead[k] = (wide_t'(sat[k]) < dz_w) && (wide_t'(sat[k]) > -dz_w);
        end
        if (!s_axis_tuser)
        begin
            for (int k = 0; k < 3; k++)
            begin
                smp[k] = res[k];
            end
        end
        else if (|dead)
        begin
            for (int k = 0; k < 3; k++)
            begin
                smp[k] = '0;
            end
        end
        else
        begin
            smp[0] = -sat[0];
            smp[1] = sat[1];
            smp[2] = sat[2];
        end
        for (int k = 0; k < 3; k++)
        begin
            if (byp_reg)
            begin
                old[k] = byp_data_reg[k*AXIS_W +: AXIS_W];
            end
            else if (vld_reg[pos_reg])
            begin
                old[k] = rd_data[k*AXIS_W +: AXIS_W];
            end
            else
            begin
                old[k] = '0;
            end
            sum_next[k] = sum_reg[k] - SUM_W'(old[k]) + SUM_W'(smp[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg      <= DEAD_ZONE_RST;
            thr_reg     <= HOLD_THR_RST;
            pos_reg     <= '0;
            vld_reg     <= '0;
            byp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                last_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_DEAD_ZONE:      dz_reg  <= cfg_wdata;
                    REG_HOLD_THRESHOLD: thr_reg <= cfg_wdata;
                endcase
            end
            byp_reg <= accept && (pos_reg == rd_addr);
            if (accept)
            begin
                pos_reg          <= pos_inc;
                vld_reg[pos_reg] <= 1'b1;
                m_valid_reg      <= 1'b1;
                for (int k = 0; k < 3; k++)
                begin
                    sum_reg[k]  <= sum_next[k];
                    last_reg[k] <= res[k];
                end
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
        if (accept)
        begin
            held_reg <= hold;
            for (int k = 0; k < 3; k++)
            begin
                out_reg[k] <= res[k];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = held_reg;
    assign m_axis_tdata  = {(TDATA_W - ENTRY_W)'(0), out_reg[2], out_reg[1], out_reg[0]};

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(WINDOW - 1))
        else $error("window pointer out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted sample produced no result");

    a_hold_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hold) |=> (out_reg[0] == $past(last_reg[0])
                              && out_reg[1] == $past(last_reg[1])
                              && out_reg[2] == $past(last_reg[2])
                              && m_axis_tuser))
        else $error("held result differs from previous output");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg[0] <= SUM_MAX) && (sum_reg[0] >= -SUM_MAX))
        else $error("roll running sum out of range");

endmodule

### hw/rtl/tdah_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tdah_ram #(
    parameter int WIDTH = 51,
    parameter int DEPTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### test/tilt_deadzone_average_hold_top_tb.sv
// Self-checking testbench for tilt_deadzone_average_hold_top: a queue-fed driver, a result
// monitor and a built-in predictor of the dead-zone, averaging and hold behavior.
// Depends on tdah_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tilt_deadzone_average_hold_top_tb;
    import tdah_pkg::*;

    localparam int WINDOW      = 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAD   = 8;
    localparam int N_PHASES    = 7;
    localparam int PHASE_ITEMS = 145;

    typedef struct packed {
        axis_t a;
        axis_t b;
        axis_t c;
        logic  vld;
    } tilt_sample_t;

    typedef struct packed {
        axis_t roll;
        axis_t pitch;
        axis_t yaw;
        logic  held;
    } tilt_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata = '0;   // raw_axis_a, raw_axis_b, raw_axis_c, zero pad
    logic                 s_axis_tuser = 1'b0; // sample_valid
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;        // out_roll, out_pitch, out_yaw, zero pad
    logic                 m_axis_tuser;        // held

    tilt_sample_t pending_tilt[$];
    tilt_out_t    predicted_out[$];

    // predictor state
    int     win_mem[WINDOW][3];
    longint win_sum[3];
    int     last_out[3];
    int     wr_slot;
    int     dead_zone_cfg = DEAD_ZONE_RST;
    int     hold_thr_cfg = HOLD_THR_RST;

    int     walk[3];
    int     err_cnt;
    int     accepted_cnt;
    int     fault_cnt;
    int     results_seen;
    int     held_seen;
    int     cycle_cnt;

    tilt_sample_t cur_sample;
    int           burst_left = 1;
    int           gap_left;

    int           rx_tick;
    int           hold_off_left;
    bit           hold_off_done;

    tilt_deadzone_average_hold_top #(
        .WINDOW(WINDOW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic int clamp_axis(input int x);
        if (x > AXIS_LIMIT)
        begin
            return AXIS_LIMIT;
        end
        if (x < -AXIS_LIMIT)
        begin
            return -AXIS_LIMIT;
        end
        return x;
    endfunction

    function automatic bit in_dead_zone(input int x);
        return (x < dead_zone_cfg) && (x > -dead_zone_cfg);
    endfunction

    task automatic smooth_tilt(input tilt_sample_t s, output tilt_out_t r);
        int     avg[3];
        int     res[3];
        int     smp[3];
        int     ax;
        int     bx;
        int     cx;
        int     diff;
        longint q;
        bit     hold;
        hold = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            q = (win_sum[k] < 0 ? -win_sum[k] : win_sum[k]) / WINDOW;
            avg[k] = (win_sum[k] < 0) ? int'(-q) : int'(q);
            diff = avg[k] - last_out[k];
            if ((diff < 0 ? -diff : diff) >= hold_thr_cfg)
            begin
                hold = 1'b0;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            res[k] = hold ? last_out[k] : avg[k];
        end
        if (s.vld)
        begin
            ax = clamp_axis(int'(s.a));
            bx = clamp_axis(int'(s.b));
            cx = clamp_axis(int'(s.c));
            if (in_dead_zone(ax) || in_dead_zone(bx) || in_dead_zone(cx))
            begin
                smp = '{0, 0, 0};
            end
            else
            begin
                smp = '{-ax, bx, cx};
            end
        end
        else
        begin
            smp = res;
        end
        for (int k = 0; k < 3; k++)
        begin
            win_sum[k] = win_sum[k] - win_mem[wr_slot][k] + smp[k];
            win_mem[wr_slot][k] = smp[k];
            last_out[k] = res[k];
        end
        wr_slot = (wr_slot + 1) % WINDOW;
        r.roll  = AXIS_W'(res[0]);
        r.pitch = AXIS_W'(res[1]);
        r.yaw   = AXIS_W'(res[2]);
        r.held  = hold;
    endtask

    task automatic queue_tilt(input int a, input int b, input int c, input bit vld);
        tilt_sample_t s;
        s.a   = AXIS_W'(a);
        s.b   = AXIS_W'(b);
        s.c   = AXIS_W'(c);
        s.vld = vld;
        pending_tilt.push_back(s);
    endtask

    // mostly slow random walks so the hold rule and dead zone both get exercised
    task automatic queue_random(input int n);
        int kind;
        int span;
        int j;
        for (int i = 0; i < n; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                case ($urandom_range(0, 3))
                    0: span = 64;
                    1: span = 600;
                    2: span = 3000;
                    default: span = 20000;
                endcase
                for (int k = 0; k < 3; k++)
                begin
                    walk[k] = clamp_axis(walk[k] + int'($urandom_range(0, 2 * span)) - span);
                end
                queue_tilt(walk[0], walk[1], walk[2], $urandom_range(0, 15) != 0);
            end
            else if (kind < 80)
            begin
                queue_tilt(int'($urandom), int'($urandom), int'($urandom), 1'b0);
            end
            else if (kind < 90)
            begin
                queue_tilt(int'($urandom), int'($urandom), int'($urandom), 1'b1);
            end
            else
            begin
                j = $urandom_range(0, 2);
                span = (dead_zone_cfg > AXIS_LIMIT) ? AXIS_LIMIT : dead_zone_cfg + 1;
                walk[j] = int'($urandom_range(0, 2 * span)) - span;
                queue_tilt(walk[0], walk[1], walk[2], 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_tilt.size() != 0 || s_axis_tvalid || predicted_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_regs(input int dz, input int thr);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEAD_ZONE;
        cfg_wdata <= CFG_W'(dz);
        @(posedge clk);
        cfg_index <= REG_HOLD_THRESHOLD;
        cfg_wdata <= CFG_W'(thr);
        @(posedge clk);
        cfg_we <= 1'b0;
        dead_zone_cfg = dz & 16'hFFFF;
        hold_thr_cfg  = thr & 16'hFFFF;
    endtask

    // request driver: bursts of random length, random gaps
    always @(posedge clk)
    begin
        tilt_out_t r;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                smooth_tilt(cur_sample, r);
                predicted_out.push_back(r);
                accepted_cnt++;
                if (!cur_sample.vld)
                begin
                    fault_cnt++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_tilt.size() != 0)
                begin
                    cur_sample = pending_tilt.pop_front();
                    s_axis_tdata  <= {5'd0, cur_sample.c, cur_sample.b, cur_sample.a};
                    s_axis_tuser  <= cur_sample.vld;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                               : $urandom_range(0, 3);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk)
    begin
        tilt_out_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (m_axis_tuser)
                begin
                    held_seen++;
                end
                if (predicted_out.size() == 0)
                begin
                    $error("result with no request pending");
                    err_cnt++;
                end
                else
                begin
                    want = predicted_out.pop_front();
                    if (m_axis_tdata[16:0] !== want.roll)
                    begin
                        $error("out_roll: expected %0d, got %0d", want.roll,
                               $signed(m_axis_tdata[16:0]));
                        err_cnt++;
                    end
                    if (m_axis_tdata[33:17] !== want.pitch)
                    begin
                        $error("out_pitch: expected %0d, got %0d", want.pitch,
                               $signed(m_axis_tdata[33:17]));
                        err_cnt++;
                    end
                    if (m_axis_tdata[50:34] !== want.yaw)
                    begin
                        $error("out_yaw: expected %0d, got %0d", want.yaw,
                               $signed(m_axis_tdata[50:34]));
                        err_cnt++;
                    end
                    if (m_axis_tuser !== want.held)
                    begin
                        $error("held: expected %0d, got %0d", want.held, m_axis_tuser);
                        err_cnt++;
                    end
                end
            end
            rx_tick++;
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_off_done && results_seen >= 300)
            begin
                hold_off_done = 1'b1;
                hold_off_left = 150;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_tick[9:8])
                    2'd0: m_axis_tready <= 1'b1;
                    2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_axis_tready <= (rx_tick[1:0] == 2'd0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tilt_deadzone_average_hold_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        int dz_set[N_PHASES];
        int thr_set[N_PHASES];
        dz_set  = '{0, 46080, 65535, 512, 1, 0, 0};
        thr_set = '{0, 46080, 65535, 2560, 1, 0, 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values, field extremes, saturation, dead zone edges, hold edges
        queue_tilt(0, 0, 0, 1'b1);
        queue_tilt(46080, 46080, 46080, 1'b1);
        queue_tilt(-46080, -46080, -46080, 1'b1);
        queue_tilt(46080, -46080, 0, 1'b1);
        queue_tilt('h0FFFF, 'h10000, 46081, 1'b1);
        queue_tilt(-46081, 'h1FFFF, 'h00001, 1'b1);
        queue_tilt(-46081, 256, -256, 1'b1);
        queue_tilt(255, 1000, 1000, 1'b1);
        queue_tilt(-255, 1000, 1000, 1'b1);
        queue_tilt(1000, 1000, 1000, 1'b1);
        queue_tilt(1000, 1000, 1000, 1'b1);
        queue_tilt(2279, 1000, 1000, 1'b1);
        queue_tilt(2279, 2279, 2279, 1'b1);
        queue_tilt(3559, 2279, 2279, 1'b1);
        queue_tilt(3559, 2279, 2279, 1'b1);
        queue_tilt('h1AAAA, 'h15555, 'h0F0F0, 1'b0);
        queue_tilt(-1000, -3000, 5000, 1'b0);
        queue_tilt(1000, -1000, 1000, 1'b1);
        queue_tilt(-20000, 30000, -40000, 1'b1);
        queue_tilt(-20000, 30000, -40000, 1'b0);
        queue_tilt('h10000, 'h10000, 'h10000, 1'b0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p >= 5)
            begin
                dz_set[p]  = $urandom_range(0, 4000);
                thr_set[p] = $urandom_range(0, 6000);
            end
            set_regs(dz_set[p], thr_set[p]);
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        $display("covered %0d samples (%0d sensor faults) under %0d register settings",
                 accepted_cnt, fault_cnt, N_PHASES + 1);
        $display("checked %0d outputs, %0d of them held", results_seen, held_seen);
        if (err_cnt == 0)
        begin
            $display("tilt_deadzone_average_hold_top: match");
        end
        else
        begin
            $display("tilt_deadzone_average_hold_top: mismatch");
        end
        $finish;
    end

endmodule
